// ----- hdl/cfc_pkg.sv -----
// Shared types, register indexes, status codes and the CRC-16 byte update
// for the command frame checker. Depends on nothing; every RTL file imports it.
`default_nettype none

package cfc_pkg;

   // One input beat: a received byte or one idle microsecond tick
   typedef struct packed {
      logic       kind;
      logic [7:0] data_byte;
   } req_type;

   // One result beat, given when a frame ends
   typedef struct packed {
      logic [7:0] command;
      logic [1:0] status;
      logic [3:0] frame_bytes;
      logic       ended_by_timeout;
   } rsp_type;

   // Item kinds
   localparam logic KIND_BYTE = 1'b0;
   localparam logic KIND_TICK = 1'b1;

   // Status codes
   localparam logic [1:0] STATUS_ACCEPTED = 2'd0;
   localparam logic [1:0] STATUS_WRONG_ID = 2'd1;
   localparam logic [1:0] STATUS_SHORT    = 2'd2;
   localparam logic [1:0] STATUS_CRC_BAD  = 2'd3;

   // Register file port
   localparam int CSR_INDEX_WIDTH = 2;
   localparam int CSR_DATA_WIDTH  = 16;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_NODE_ADDR    = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_IDLE_TIMEOUT = 2'd1;

   // Reset values and CRC constants
   localparam logic [7:0]  NODE_ADDR_RESET    = 8'd1;
   localparam logic [15:0] IDLE_TIMEOUT_RESET = 16'd50000;
   localparam logic [15:0] IDLE_MAX           = 16'hFFFF;
   localparam logic [15:0] CRC_INIT           = 16'hFFFF;
   localparam logic [15:0] CRC_POLY           = 16'hA001;

   // CRC-16/MODBUS update by one byte, reflected, eight shift steps
   function automatic logic [15:0] crc_byte(input logic [15:0] crc_i,
                                            input logic [7:0]  byte_i);
      logic [15:0] c;
      c = crc_i ^ {8'h00, byte_i};
      for (int k = 0; k < 8; k++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

endpackage

`default_nettype wire

// ----- hdl/cfc_csr_regs.sv -----
// Configuration registers of the command frame checker: node address and
// idle timeout. Depends on cfc_pkg.
`default_nettype none

module cfc_csr_regs import cfc_pkg::*; (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       csr_valid,
   output logic                            csr_ready,
   input  wire logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  wire logic [CSR_DATA_WIDTH-1:0]  csr_wdata,
   output logic [7:0]                      node_addr,
   output logic [15:0]                     idle_timeout
);

   logic [7:0]  node_addr_ff;
   logic [15:0] idle_timeout_ff;

   // Always take a write; unknown indexes fall through
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         node_addr_ff    <= NODE_ADDR_RESET;
         idle_timeout_ff <= IDLE_TIMEOUT_RESET;
      end else if (csr_valid) begin
         if (csr_index == CSR_NODE_ADDR) begin
            node_addr_ff <= csr_wdata[7:0];
         end
         if (csr_index == CSR_IDLE_TIMEOUT) begin
            idle_timeout_ff <= csr_wdata[15:0];
         end
      end
   end

   assign node_addr    = node_addr_ff;
   assign idle_timeout = idle_timeout_ff;

endmodule

`default_nettype wire

// ----- hdl/cfc_input_stage.sv -----
// Input register of the command frame checker: holds one request beat
// until the frame engine takes it. Depends on cfc_pkg.
`default_nettype none

module cfc_input_stage import cfc_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire req_type req_data,
   input  wire logic    take,
   output logic         item_valid,
   output req_type      item
);

   logic    valid_ff;
   logic    valid_in;
   req_type item_ff;

   // Stall only while a held beat cannot move on
   assign req_stall = valid_ff && !take;
   assign valid_in  = req_stall ? valid_ff : req_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Load payload on every accepted beat
   always_ff @(posedge clock) begin
      if (!req_stall && req_valid) begin
         item_ff <= req_data;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

`default_nettype wire

// ----- hdl/cfc_frame_engine.sv -----
// Frame state and end-of-frame check of the command frame checker: tracks
// byte count, idle time, running CRC and header fields. Depends on cfc_pkg.
`default_nettype none

module cfc_frame_engine import cfc_pkg::*; #(
   parameter int BUFFER_BYTES = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        fire,
   input  wire req_type     item,
   input  wire logic [7:0]  node_addr,
   input  wire logic [15:0] idle_timeout,
   output logic             res_valid,
   output rsp_type          res
);

   localparam int CW = $clog2(BUFFER_BYTES);
   localparam int EW = ((CW > 8) ? CW : 8) + 2;
   localparam logic [EW-1:0] LIMIT = EW'(BUFFER_BYTES - 1);

   logic [CW-1:0] byte_count_ff, byte_count_in, count_upd;
   logic [15:0]   idle_count_ff, idle_count_in, idle_upd;
   logic [15:0]   running_crc_ff, running_crc_in, crc_upd;
   logic          id_matched_ff, id_matched_in, id_upd;
   logic [7:0]    command_seen_ff, command_seen_in, command_upd;
   logic [7:0]    length_seen_ff, length_seen_in, length_upd;
   logic [15:0]   crc_snapshot_ff, crc_snapshot_in, snapshot_upd;
   logic [15:0]   crc_received_ff, crc_received_in, received_upd;

   logic          finish;
   logic          by_timeout;
   logic [EW-1:0] idx;
   logic [EW-1:0] len_ext;
   logic [EW-1:0] count_next;

   assign idx = EW'(byte_count_ff);

   // Advance the frame state for one beat
   always_comb begin
      count_upd    = byte_count_ff;
      idle_upd     = idle_count_ff;
      crc_upd      = running_crc_ff;
      id_upd       = id_matched_ff;
      command_upd  = command_seen_ff;
      length_upd   = length_seen_ff;
      snapshot_upd = crc_snapshot_ff;
      received_upd = crc_received_ff;
      finish       = 1'b0;
      by_timeout   = 1'b0;
      count_next   = idx + EW'(1);
      len_ext      = EW'(length_seen_ff);
      if (fire) begin
         if (item.kind == KIND_TICK) begin
            // Count idle time only with a frame open
            if (byte_count_ff != '0) begin
               idle_upd = (idle_count_ff != IDLE_MAX) ? idle_count_ff + 16'd1
                                                      : idle_count_ff;
               if (idle_upd >= idle_timeout) begin
                  finish     = 1'b1;
                  by_timeout = 1'b1;
               end
            end
         end else begin
            idle_upd = '0;
            if (idx == EW'(0)) begin
               id_upd = (item.data_byte == node_addr);
            end
            if (idx == EW'(1)) begin
               command_upd = item.data_byte;
            end
            if (idx == EW'(2)) begin
               length_upd = item.data_byte;
            end
            len_ext = EW'(length_upd);
            // Fold header and data bytes into the CRC
            if (idx < EW'(3) || idx < len_ext + EW'(3)) begin
               crc_upd = crc_byte(running_crc_ff, item.data_byte);
            end
            if (idx >= EW'(2) && idx == len_ext + EW'(2)) begin
               snapshot_upd = crc_upd;
            end
            if (idx >= EW'(3) && idx == len_ext + EW'(3)) begin
               received_upd = {item.data_byte, crc_received_ff[7:0]};
            end
            if (idx >= EW'(4) && idx == len_ext + EW'(4)) begin
               received_upd = {crc_received_ff[15:8], item.data_byte};
            end
            count_upd = CW'(count_next);
            if (count_next >= LIMIT) begin
               finish = 1'b1;
            end
         end
      end
   end

   // Judge the ended frame: id, then length, then CRC
   always_comb begin
      logic [EW-1:0] fin_count;
      fin_count            = EW'(count_upd);
      res.command          = 8'h00;
      res.frame_bytes      = fin_count[3:0];
      res.ended_by_timeout = by_timeout;
      if (!id_upd) begin
         res.status = STATUS_WRONG_ID;
      end else if (fin_count < EW'(3) || fin_count < len_ext + EW'(5)) begin
         res.status = STATUS_SHORT;
      end else if (snapshot_upd != received_upd) begin
         res.status = STATUS_CRC_BAD;
      end else begin
         res.status  = STATUS_ACCEPTED;
         res.command = command_upd;
      end
   end

   assign res_valid = finish;

   // Clear the frame when it ends
   always_comb begin
      if (finish) begin
         byte_count_in   = '0;
         idle_count_in   = '0;
         running_crc_in  = CRC_INIT;
         id_matched_in   = 1'b0;
         command_seen_in = '0;
         length_seen_in  = '0;
         crc_snapshot_in = '0;
         crc_received_in = '0;
      end else begin
         byte_count_in   = count_upd;
         idle_count_in   = idle_upd;
         running_crc_in  = crc_upd;
         id_matched_in   = id_upd;
         command_seen_in = command_upd;
         length_seen_in  = length_upd;
         crc_snapshot_in = snapshot_upd;
         crc_received_in = received_upd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_count_ff   <= '0;
         idle_count_ff   <= '0;
         running_crc_ff  <= CRC_INIT;
         id_matched_ff   <= 1'b0;
         command_seen_ff <= '0;
         length_seen_ff  <= '0;
         crc_snapshot_ff <= '0;
         crc_received_ff <= '0;
      end else begin
         byte_count_ff   <= byte_count_in;
         idle_count_ff   <= idle_count_in;
         running_crc_ff  <= running_crc_in;
         id_matched_ff   <= id_matched_in;
         command_seen_ff <= command_seen_in;
         length_seen_ff  <= length_seen_in;
         crc_snapshot_ff <= crc_snapshot_in;
         crc_received_ff <= crc_received_in;
      end
   end

endmodule

`default_nettype wire

// ----- hdl/cfc_output_stage.sv -----
// Result register of the command frame checker: holds one result beat
// until the consumer takes it. Depends on cfc_pkg.
`default_nettype none

module cfc_output_stage import cfc_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    load,
   input  wire rsp_type res,
   output logic         slot_free,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp_data
);

   logic    valid_ff;
   logic    valid_in;
   rsp_type data_ff;

   // Free when empty or when the held beat leaves this cycle
   assign slot_free = !valid_ff || !rsp_stall;

   always_comb begin
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_stall) begin
         valid_in = valid_ff;
      end else begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= res;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule

`default_nettype wire

// ----- hdl/command_frame_checker_unit.sv -----
// Top level of the command frame checker: input register, frame engine,
// result register and configuration registers. Depends on cfc_pkg and the cfc_* modules.
//
//   channel | direction | handshake           | payload
//   req_    | in        | req_valid/req_stall | req_type: kind, data_byte
//   rsp_    | out       | rsp_valid/rsp_stall | rsp_type: command, status, frame_bytes,
//           |           |                     |           ended_by_timeout
//   csr_    | in        | csr_valid/csr_ready | csr_index, csr_wdata
//
// One beat per cycle unless a stall holds it: a byte or tick lands in the input
// register, the frame engine updates state and judges the frame from that register,
// and the result register loads the outcome, so rsp_valid follows the closing beat
// through both registers. The combinational CRC byte update sets the critical path.
// Synchronous active-high reset clears all frame state and loads register defaults.
// A stalled result register holds the engine; the input register then stalls req_.
`default_nettype none

module command_frame_checker_unit import cfc_pkg::*; #(
   parameter int BUFFER_BYTES = 16
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   output logic                            req_stall,
   input  wire req_type                    req_data,
   output logic                            rsp_valid,
   input  wire logic                       rsp_stall,
   output rsp_type                         rsp_data,
   input  wire logic                       csr_valid,
   output logic                            csr_ready,
   input  wire logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  wire logic [CSR_DATA_WIDTH-1:0]  csr_wdata
);

   logic        item_valid;
   req_type     item;
   logic        slot_free;
   logic        fire;
   logic        res_valid;
   rsp_type     res;
   logic [7:0]  node_addr;
   logic [15:0] idle_timeout;

   // Advance a held beat when the result slot can take its outcome
   assign fire = item_valid && slot_free;

   cfc_csr_regs u_csr (
      .clock        (clock),
      .reset        (reset),
      .csr_valid    (csr_valid),
      .csr_ready    (csr_ready),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .node_addr    (node_addr),
      .idle_timeout (idle_timeout)
   );

   cfc_input_stage u_in (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .take       (fire),
      .item_valid (item_valid),
      .item       (item)
   );

   cfc_frame_engine #(
      .BUFFER_BYTES (BUFFER_BYTES)
   ) u_engine (
      .clock        (clock),
      .reset        (reset),
      .fire         (fire),
      .item         (item),
      .node_addr    (node_addr),
      .idle_timeout (idle_timeout),
      .res_valid    (res_valid),
      .res          (res)
   );

   cfc_output_stage u_out (
      .clock     (clock),
      .reset     (reset),
      .load      (res_valid),
      .res       (res),
      .slot_free (slot_free),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

// ----- tb/tb_command_frame_checker_unit.sv -----
// Self-checking testbench for command_frame_checker_unit: directed frames from a stimulus
// table, then random frames checked against an in-bench frame tracker and CRC-16 mirror.
// Depends on cfc_pkg and the command_frame_checker_unit RTL.
`default_nettype none

module tb_command_frame_checker_unit;
   import cfc_pkg::*;

   localparam int BUFFER_BYTES  = 16;
   localparam int RANDOM_BEATS  = 460;
   localparam int QUIET_CYCLES  = 8;
   localparam int HOLD_CYCLES   = 400;
   localparam int CYCLE_LIMIT   = 1000000;
   localparam int SEGMENTS      = 6;

   // Register indexes that map to no register
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_UNUSED_2 = 2'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_UNUSED_3 = 2'd3;

   typedef enum {ROW_BYTE, ROW_TICKS, ROW_CRC_HI, ROW_CRC_LO, ROW_CRC_BAD, ROW_REG} row_op_type;

   typedef struct {
      row_op_type                 op;
      int unsigned                arg;
      logic [CSR_INDEX_WIDTH-1:0] idx;
      bit                         typed;
      rsp_type                    want;
   } stim_row_type;

   logic                       clock     = 1'b0;
   logic                       reset     = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_stall;
   req_type                    req_data  = '0;
   logic                       rsp_valid;
   logic                       rsp_stall = 1'b0;
   rsp_type                    rsp_data;
   logic                       csr_valid = 1'b0;
   logic                       csr_ready;
   logic [CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [CSR_DATA_WIDTH-1:0]  csr_wdata = '0;

   // Typed expectation that travels with the beat on req_
   bit      beat_typed = 1'b0;
   rsp_type beat_want  = '0;

   // Mirror of the configuration and of the frame being collected
   logic [7:0]  cfg_device;
   logic [15:0] cfg_timeout;
   int unsigned fr_count;
   int unsigned fr_idle;
   int unsigned fr_len;
   logic [15:0] fr_crc;
   logic [15:0] fr_crc_calc;
   logic [15:0] fr_crc_rx;
   logic        fr_id_ok;
   logic [7:0]  fr_cmd;

   rsp_type      expected_verdicts[$];
   stim_row_type directed_rows[$];

   int  mismatches       = 0;
   int  cycles           = 0;
   int  beats_accepted   = 0;
   int  frame_beats      = 0;
   int  verdicts_seen    = 0;
   int  sender_gap_pct   = 0;
   int  receiver_gap_pct = 0;
   bit  hold_request     = 1'b0;

   command_frame_checker_unit #(.BUFFER_BYTES(BUFFER_BYTES)) DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #5 clock = ~clock;

   // ---------------------------------------------------------------- frame tracker

   // Advance a CRC-16/MODBUS accumulator by one byte, LSB first
   function automatic logic [15:0] modbus_crc_update(input logic [15:0] acc,
                                                     input logic [7:0]  b);
      logic [15:0] c;
      int          k;
      c = acc ^ {8'h00, b};
      for (k = 0; k < 8; k++) begin
         if (c[0]) c = {1'b0, c[15:1]} ^ CRC_POLY;
         else c = {1'b0, c[15:1]};
      end
      return c;
   endfunction

   function automatic void clear_frame();
      fr_count    = 0;
      fr_idle     = 0;
      fr_len      = 0;
      fr_crc      = CRC_INIT;
      fr_crc_calc = '0;
      fr_crc_rx   = '0;
      fr_id_ok    = 1'b0;
      fr_cmd      = '0;
   endfunction

   function automatic rsp_type outcome(input logic [7:0] cmd, input logic [1:0] st,
                                       input logic [3:0] n, input logic by_timeout);
      rsp_type r;
      r.command          = cmd;
      r.status           = st;
      r.frame_bytes      = n;
      r.ended_by_timeout = by_timeout;
      return r;
   endfunction

   // Judge the open frame in check order id, length, CRC, then start a fresh one
   function automatic rsp_type judge_frame(input logic by_timeout);
      rsp_type r;
      r = outcome(8'h00, STATUS_ACCEPTED, fr_count[3:0], by_timeout);
      if (!fr_id_ok) r.status = STATUS_WRONG_ID;
      else if (fr_count < 3 || fr_count < fr_len + 5) r.status = STATUS_SHORT;
      else if (fr_crc_calc != fr_crc_rx) r.status = STATUS_CRC_BAD;
      else r.command = fr_cmd;
      clear_frame();
      return r;
   endfunction

   // Apply one accepted beat; return 1 when it closes a frame
   function automatic bit track_frame_beat(input req_type beat, output rsp_type verdict,
                                           output bit ignored);
      int unsigned pos;
      ignored = 1'b0;
      verdict = '0;
      if (beat.kind == KIND_TICK) begin
         if (fr_count == 0) begin
            ignored = 1'b1;
            return 1'b0;
         end
         if (fr_idle < 32'hFFFF) fr_idle++;
         if (fr_idle >= cfg_timeout) begin
            verdict = judge_frame(1'b1);
            return 1'b1;
         end
         return 1'b0;
      end
      pos     = fr_count;
      fr_idle = 0;
      if (pos == 0) fr_id_ok = (beat.data_byte == cfg_device);
      else if (pos == 1) fr_cmd = beat.data_byte;
      else if (pos == 2) fr_len = beat.data_byte;
      // CRC covers id, command, length and data only
      if (pos < 3 || pos < fr_len + 3) fr_crc = modbus_crc_update(fr_crc, beat.data_byte);
      if (pos >= 2 && pos == fr_len + 2) fr_crc_calc = fr_crc;
      if (pos >= 3 && pos == fr_len + 3) fr_crc_rx[15:8] = beat.data_byte;
      if (pos >= 4 && pos == fr_len + 4) fr_crc_rx[7:0] = beat.data_byte;
      fr_count = pos + 1;
      if (fr_count >= BUFFER_BYTES - 1) begin
         verdict = judge_frame(1'b0);
         return 1'b1;
      end
      return 1'b0;
   endfunction

   // ---------------------------------------------------------------- checking

   task automatic report_mismatch(input string what);
      mismatches++;
      $display("MISMATCH cycle %0d: %s", cycles, what);
   endtask

   // Predict on each accepted req_ beat, compare each accepted rsp_ beat
   always @(posedge clock) begin : monitor
      rsp_type predicted;
      rsp_type want;
      bit      made;
      bit      ignored;
      if (reset) begin
         cfg_device  = NODE_ADDR_RESET;
         cfg_timeout = IDLE_TIMEOUT_RESET;
         clear_frame();
      end else begin
         if (req_valid && !req_stall) begin
            made = track_frame_beat(req_data, predicted, ignored);
            beats_accepted++;
            if (!ignored) frame_beats++;
            if (beat_typed) expected_verdicts.push_back(beat_want);
            else if (made) expected_verdicts.push_back(predicted);
         end
         if (rsp_valid && !rsp_stall) begin
            verdicts_seen++;
            if (expected_verdicts.size() == 0) begin
               report_mismatch($sformatf("unexpected result %p", rsp_data));
            end else begin
               want = expected_verdicts.pop_front();
               if (rsp_data.command != want.command)
                  report_mismatch($sformatf("command %0h, want %0h",
                                            rsp_data.command, want.command));
               if (rsp_data.status != want.status)
                  report_mismatch($sformatf("status %0d, want %0d",
                                            rsp_data.status, want.status));
               if (rsp_data.frame_bytes != want.frame_bytes)
                  report_mismatch($sformatf("frame_bytes %0d, want %0d",
                                            rsp_data.frame_bytes, want.frame_bytes));
               if (rsp_data.ended_by_timeout != want.ended_by_timeout)
                  report_mismatch($sformatf("ended_by_timeout %0b, want %0b",
                                            rsp_data.ended_by_timeout,
                                            want.ended_by_timeout));
            end
         end
      end
   end

   // Stop a hung run
   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results pending", cycles,
                  expected_verdicts.size());
         $display("end of test: mismatches");
         $finish;
      end
   end

   // ---------------------------------------------------------------- result side

   // Stall rsp_ at random; hold off for a long stretch on request
   initial begin
      forever begin
         @(negedge clock);
         if (hold_request) begin
            for (int n = 0; n < HOLD_CYCLES; n++) begin
               rsp_stall <= 1'b1;
               @(negedge clock);
            end
            hold_request = 1'b0;
         end
         rsp_stall <= ($urandom_range(99) < receiver_gap_pct);
      end
   end

   // ---------------------------------------------------------------- stimulus

   // Offer one beat from a falling edge and return at the falling edge after it lands
   task automatic send_beat(input logic kind, input logic [7:0] value, input bit typed,
                            input rsp_type want);
      req_type beat;
      while ($urandom_range(99) < sender_gap_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      beat.kind      = kind;
      beat.data_byte = value;
      req_valid  <= 1'b1;
      req_data   <= beat;
      beat_typed <= typed;
      beat_want  <= want;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic send_byte(input logic [7:0] value);
      send_beat(KIND_BYTE, value, 1'b0, '0);
   endtask

   task automatic send_tick();
      send_beat(KIND_TICK, 8'($urandom), 1'b0, '0);
   endtask

   // Pause the sender until every expected result has come
   task automatic drain();
      req_valid <= 1'b0;
      while (expected_verdicts.size() != 0) @(negedge clock);
   endtask

   // Write one register once the block has gone quiet
   task automatic write_reg(input logic [CSR_INDEX_WIDTH-1:0] idx,
                            input logic [CSR_DATA_WIDTH-1:0] value);
      drain();
      repeat (QUIET_CYCLES) @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      if (idx == CSR_NODE_ADDR) cfg_device = value[7:0];
      else if (idx == CSR_IDLE_TIMEOUT) cfg_timeout = value[15:0];
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Close the open frame with idle ticks
   task automatic tick_until_closed();
      while (fr_count != 0) send_tick();
   endtask

   // One random frame: mostly well formed, the rest noise and broken frames
   task automatic send_frame();
      int unsigned shape;
      int unsigned len;
      int unsigned n;
      int unsigned k;
      logic [7:0]  flip;
      shape = $urandom_range(99);
      // stray tick with no frame open
      if ($urandom_range(7) == 0) send_tick();
      if (shape < 72) begin
         len  = ($urandom_range(3) == 0) ? $urandom_range(10) : $urandom_range(4);
         flip = ($urandom_range(11) == 0) ? 8'($urandom_range(1, 255)) : 8'h00;
         send_byte(($urandom_range(9) != 0) ? cfg_device : 8'($urandom));
         send_byte(8'($urandom));
         send_byte(8'(len));
         for (k = 0; k < len; k++) send_byte(8'($urandom));
         send_byte(fr_crc[15:8]);
         send_byte(fr_crc[7:0] ^ flip);
         if (fr_count != 0) begin
            case ($urandom_range(2))
               0: begin
                  // extra bytes up to the buffer limit
                  while (fr_count != 0) send_byte(8'($urandom));
               end
               1: begin
                  // some idle, then one more byte restarts the idle count
                  if (cfg_timeout > 1) begin
                     n = $urandom_range(1, cfg_timeout - 1);
                     for (k = 0; k < n; k++) send_tick();
                     send_byte(8'($urandom));
                  end
                  tick_until_closed();
               end
               default: tick_until_closed();
            endcase
         end
      end else begin
         n = $urandom_range(1, 16);
         if ($urandom_range(1) == 0) send_byte(cfg_device);
         for (k = 0; k < n; k++) begin
            if ($urandom_range(5) == 0) send_tick();
            else send_byte(8'($urandom));
         end
         tick_until_closed();
      end
   endtask

   function automatic void put(input row_op_type op, input int unsigned arg);
      stim_row_type r;
      r.op    = op;
      r.arg   = arg;
      r.idx   = '0;
      r.typed = 1'b0;
      r.want  = '0;
      directed_rows.push_back(r);
   endfunction

   function automatic void put_typed(input row_op_type op, input int unsigned arg,
                                     input rsp_type want);
      put(op, arg);
      directed_rows[$].typed = 1'b1;
      directed_rows[$].want  = want;
   endfunction

   function automatic void put_reg(input logic [CSR_INDEX_WIDTH-1:0] idx,
                                   input int unsigned value);
      put(ROW_REG, value);
      directed_rows[$].idx = idx;
   endfunction

   initial begin : stimulus
      int          seg;
      int          frames;
      int          goal;
      int          base;
      bit          last;
      logic [7:0]  dev;
      logic [15:0] tmo;

      // Directed frames; typed rows carry a result readable at a glance
      put(ROW_TICKS, 1);                                          // tick with no frame
      // idle under the reset timeout, then fill the buffer with a long length
      put(ROW_BYTE, 8'h01); put(ROW_TICKS, 10);
      put(ROW_BYTE, 8'h10); put(ROW_BYTE, 8'hFF);
      for (int k = 0; k < 11; k++) put(ROW_BYTE, 8'h00);
      put_typed(ROW_BYTE, 8'h00, outcome(8'h00, STATUS_SHORT, 4'd15, 1'b0));
      put_reg(CSR_IDLE_TIMEOUT, 1);
      put(ROW_BYTE, 8'h07);
      put_typed(ROW_TICKS, 1, outcome(8'h00, STATUS_WRONG_ID, 4'd1, 1'b1));
      put(ROW_BYTE, 8'h01); put(ROW_BYTE, 8'h03); put(ROW_BYTE, 8'h00);
      put(ROW_CRC_HI, 0); put(ROW_CRC_LO, 0); put(ROW_TICKS, 1);  // good frame
      put(ROW_BYTE, 8'h01); put(ROW_BYTE, 8'hFF); put(ROW_BYTE, 8'h01); put(ROW_BYTE, 8'h00);
      put(ROW_CRC_HI, 0); put(ROW_CRC_BAD, 0);
      put_typed(ROW_TICKS, 1, outcome(8'h00, STATUS_CRC_BAD, 4'd6, 1'b1));
      put(ROW_BYTE, 8'h01); put(ROW_BYTE, 8'h00); put(ROW_BYTE, 8'h04);
      put(ROW_BYTE, 8'hFF); put(ROW_BYTE, 8'h80);                 // length past the data
      put_typed(ROW_TICKS, 1, outcome(8'h00, STATUS_SHORT, 4'd5, 1'b1));
      put_reg(CSR_NODE_ADDR, 16'hA5FF);
      put(ROW_BYTE, 8'hFF); put(ROW_BYTE, 8'h5A); put(ROW_BYTE, 8'h00);
      put(ROW_CRC_HI, 0); put(ROW_CRC_LO, 0);
      put(ROW_BYTE, 8'h00); put(ROW_BYTE, 8'hFF); put(ROW_TICKS, 1);  // trailing bytes
      put_reg(CSR_IDLE_TIMEOUT, 0);
      put(ROW_BYTE, 8'hFF);
      put_typed(ROW_TICKS, 1, outcome(8'h00, STATUS_SHORT, 4'd1, 1'b1));
      put_reg(CSR_NODE_ADDR, 16'h7F00);
      put(ROW_BYTE, 8'h00);
      put_reg(CSR_NODE_ADDR, 16'h0033);                           // id already sampled
      put(ROW_BYTE, 8'h81); put(ROW_BYTE, 8'h00);
      put(ROW_CRC_HI, 0); put(ROW_CRC_LO, 0); put(ROW_TICKS, 1);
      put_reg(CSR_UNUSED_2, 16'hFFFF);
      put_reg(CSR_UNUSED_3, 16'hFFFF);
      put_reg(CSR_IDLE_TIMEOUT, 16'hFFFF);
      put(ROW_BYTE, 8'h33); put(ROW_TICKS, 3);
      put_reg(CSR_IDLE_TIMEOUT, 2);                               // lowered mid-frame
      put_typed(ROW_TICKS, 1, outcome(8'h00, STATUS_SHORT, 4'd1, 1'b1));

      sender_gap_pct   = 8;
      receiver_gap_pct = 70;
      repeat (7) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Walk the table
      foreach (directed_rows[r]) begin
         case (directed_rows[r].op)
            ROW_BYTE:
               send_beat(KIND_BYTE, 8'(directed_rows[r].arg), directed_rows[r].typed,
                         directed_rows[r].want);
            ROW_TICKS:
               for (int unsigned k = 1; k <= directed_rows[r].arg; k++) begin
                  last = (k == directed_rows[r].arg);
                  send_beat(KIND_TICK, 8'($urandom), directed_rows[r].typed && last,
                            directed_rows[r].want);
               end
            ROW_CRC_HI:
               send_beat(KIND_BYTE, fr_crc[15:8], directed_rows[r].typed,
                         directed_rows[r].want);
            ROW_CRC_LO:
               send_beat(KIND_BYTE, fr_crc[7:0], directed_rows[r].typed,
                         directed_rows[r].want);
            ROW_CRC_BAD:
               send_beat(KIND_BYTE, ~fr_crc[7:0], directed_rows[r].typed,
                         directed_rows[r].want);
            default:
               write_reg(directed_rows[r].idx, 16'(directed_rows[r].arg));
         endcase
      end

      // Random segments, each under its own register setting
      base = frame_beats;
      for (seg = 0; seg < SEGMENTS; seg++) begin
         case (seg)
            0: begin dev = 8'h00;         tmo = 16'd1; end
            1: begin dev = 8'hFF;         tmo = 16'd4; end
            2: begin dev = 8'($urandom);  tmo = 16'($urandom_range(2, 16)); end
            3: begin dev = 8'($urandom);  tmo = 16'd0; end
            4: begin dev = 8'hFF;         tmo = 16'($urandom_range(1, 8)); end
            default: begin dev = 8'($urandom); tmo = 16'd3; end
         endcase
         write_reg(CSR_NODE_ADDR, {8'($urandom), dev});
         write_reg(CSR_IDLE_TIMEOUT, tmo);
         write_reg((seg % 2 == 0) ? CSR_UNUSED_2 : CSR_UNUSED_3, 16'($urandom));
         // sender idles lightly first, then the receiver, then neither
         sender_gap_pct   = (seg < 2) ? 8 : (seg < 4) ? 70 : 0;
         receiver_gap_pct = (seg < 2) ? 70 : (seg < 4) ? 8 : 0;
         // long receiver hold-off while frames keep coming in
         if (seg == 4) hold_request = 1'b1;
         goal   = base + RANDOM_BEATS * (seg + 1) / SEGMENTS;
         frames = 0;
         while (frame_beats < goal) begin
            send_frame();
            frames++;
            if (frames == 5) drain();
         end
      end

      // Wait out the pipeline, then judge the run
      drain();
      repeat (QUIET_CYCLES) @(negedge clock);
      if (expected_verdicts.size() != 0)
         report_mismatch($sformatf("%0d results never arrived", expected_verdicts.size()));
      $display("covered %0d directed rows and %0d random register settings",
               directed_rows.size(), SEGMENTS);
      $display("%0d beats accepted, %0d frame results checked, %0d mismatches",
               beats_accepted, verdicts_seen, mismatches);
      if (mismatches == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

`default_nettype wire
